// File: hdl/proximity_avoidance_mixer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the proximity avoidance mixer
// Shorthand for the clocked, reset-qualified checks in the top level.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_AVOIDANCE_MIXER_CORE_MACROS_SVH
`define PROXIMITY_AVOIDANCE_MIXER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pam_pkg.sv
// ----------------------------------------------------------------------------
// pam_pkg
// Shared constants, weight table and types of the proximity avoidance mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package pam_pkg;

  localparam int SENSOR_COUNT   = 8;
  localparam int SENSOR_BITS    = 12;
  localparam int WEIGHT_ENTRIES = 16;
  localparam int WEIGHT_BITS    = 8;
  localparam int WIDX_BITS      = $clog2(WEIGHT_ENTRIES);

  localparam int REQ_BITS      = 11;
  localparam int SPEED_BITS    = 11;
  localparam int BASE_BITS     = 10;
  localparam int LIMIT_BITS    = 10;
  localparam int THRESH_BITS   = 15;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 15;

  localparam int SUM_DIVISOR  = 300;
  localparam int FULL_SCALE   = 4096;
  localparam int REDUCE_SHIFT = $clog2(2 * FULL_SCALE);

  // Datapath widths.
  localparam int PROD_W    = SENSOR_BITS + WEIGHT_BITS;
  localparam int SUM_W     = PROD_W + $clog2(SENSOR_COUNT);
  localparam int TOT_W     = SENSOR_BITS + $clog2(SENSOR_COUNT);
  localparam int MAG_W     = SUM_W;
  localparam int DIV_SHIFT = MAG_W + 1;
  localparam longint RECIP = (longint'(1) << DIV_SHIFT) / SUM_DIVISOR;
  localparam int RECIP_W   = DIV_SHIFT - $clog2(SUM_DIVISOR) + 1;
  localparam int Q_W       = MAG_W - $clog2(SUM_DIVISOR) + 1;
  localparam int QS_W      = Q_W + 1;
  localparam int RP_W      = REQ_BITS + SENSOR_BITS + 1;
  localparam int RED_W     = ((RP_W - REDUCE_SHIFT > REQ_BITS) ?
                              (RP_W - REDUCE_SHIFT) : REQ_BITS) + 1;
  localparam int MIX_W     = ((QS_W > RED_W) ? QS_W : RED_W) + 2;
  localparam int CMP_W     = (TOT_W > THRESH_BITS) ? TOT_W : THRESH_BITS;

  localparam int IN_DATA_BITS  = ((SENSOR_COUNT * SENSOR_BITS + 2 * REQ_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * SPEED_BITS + 7) / 8) * 8;

  localparam logic signed [BASE_BITS-1:0] BASE_RESET      = 10'sd150;
  localparam logic [LIMIT_BITS-1:0]       LIMIT_RESET     = 10'd800;
  localparam logic [THRESH_BITS-1:0]      THRESHOLD_RESET = 15'd2400;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_BASE_OFFSET        = 2'd0,
    CFG_SPEED_LIMIT        = 2'd1,
    CFG_ACTIVITY_THRESHOLD = 2'd2
  } cfg_index_t;

  typedef logic [SENSOR_BITS-1:0]        sensor_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [TOT_W-1:0]              total_t;
  typedef logic signed [REQ_BITS-1:0]    req_t;
  typedef logic signed [SPEED_BITS-1:0]  speed_t;

  // Right sum uses entries 0..N-1, left sum the entries after them.
  localparam weight_t WEIGHT_TABLE [WEIGHT_ENTRIES] = '{
    8'sd17,  8'sd29,  8'sd34,  8'sd10,  8'sd8,  -8'sd38, -8'sd56, -8'sd76,
    -8'sd72, -8'sd58, -8'sd36, 8'sd8,   8'sd10, 8'sd36,  8'sd28,  8'sd18
  };

  typedef struct packed {
    prod_t   prod_right;
    prod_t   prod_left;
    sensor_t sensor;
  } lane_out_t;

  typedef struct packed {
    sum_t    sum_right;
    sum_t    sum_left;
    total_t  total;
    sensor_t peak;
    req_t    req_left;
    req_t    req_right;
  } frame_sum_t;

  typedef struct packed {
    logic signed [BASE_BITS-1:0] base_offset;
    logic [LIMIT_BITS-1:0]       speed_limit;
    logic [THRESH_BITS-1:0]      activity_threshold;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic so;
  } stage_en_t;

  // Sensors whose entry falls past the table get no weight.
  function automatic weight_t weight_at(input int idx);
    weight_t               w;
    logic [WIDX_BITS-1:0]  ix;
    ix = idx[WIDX_BITS-1:0];
    w  = '0;
    if (idx < WEIGHT_ENTRIES) begin
      w = WEIGHT_TABLE[ix];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pam_lane.sv
// ----------------------------------------------------------------------------
// pam_lane
// One sensor lane: weights the reading for the right and the left sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_lane
  import pam_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  sensor_t   sensor,
  input  weight_t   w_right,
  input  weight_t   w_left,
  output lane_out_t lane_q
);

  prod_t   sens_x;
  prod_t   wr_x;
  prod_t   wl_x;
  prod_t   prod_right_r;
  prod_t   prod_left_r;
  sensor_t sensor_r;

  assign sens_x = prod_t'({1'b0, sensor});
  assign wr_x   = prod_t'(w_right);
  assign wl_x   = prod_t'(w_left);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_right_r <= sens_x * wr_x;
      prod_left_r  <= sens_x * wl_x;
      sensor_r     <= sensor;
    end
  end

  assign lane_q = '{prod_right: prod_right_r, prod_left: prod_left_r, sensor: sensor_r};

endmodule

`default_nettype wire

// File: hdl/pam_merge.sv
// ----------------------------------------------------------------------------
// pam_merge
// Combines the lanes: both weighted sums, the reading total and the peak.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_merge
  import pam_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  lane_out_t  lanes [SENSOR_COUNT],
  input  req_t       req_left,
  input  req_t       req_right,
  output frame_sum_t frame_q
);

  sum_t       acc_right;
  sum_t       acc_left;
  total_t     acc_total;
  sensor_t    acc_peak;
  frame_sum_t frame_r;

  always_comb begin
    acc_right = '0;
    acc_left  = '0;
    acc_total = '0;
    acc_peak  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      acc_right = acc_right + sum_t'($signed(lanes[i].prod_right));
      acc_left  = acc_left + sum_t'($signed(lanes[i].prod_left));
      acc_total = acc_total + total_t'(lanes[i].sensor);
      if (lanes[i].sensor > acc_peak) begin
        acc_peak = lanes[i].sensor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_r.sum_right <= acc_right;
      frame_r.sum_left  <= acc_left;
      frame_r.total     <= acc_total;
      frame_r.peak      <= acc_peak;
      frame_r.req_left  <= req_left;
      frame_r.req_right <= req_right;
    end
  end

  assign frame_q = frame_r;

endmodule

`default_nettype wire

// File: hdl/pam_post.sv
// ----------------------------------------------------------------------------
// pam_post
// Scales the sums by 1/300, reduces the requests near obstacles and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_post
  import pam_pkg::*;
(
  input  logic       clk,
  input  stage_en_t  en,
  input  cfg_t       cfg,
  input  frame_sum_t frame,
  output speed_t     left_speed,
  output speed_t     right_speed
);

  // Stage 3: magnitudes, request products, activity flag.
  sum_t                    sum_l_s;
  sum_t                    sum_r_s;
  logic [MAG_W-1:0]        mag_l;
  logic [MAG_W-1:0]        mag_r;
  logic signed [RP_W-1:0]  rp_l;
  logic signed [RP_W-1:0]  rp_r;
  logic signed [RP_W-1:0]  peak_x;
  logic                    active;

  logic [MAG_W-1:0]        mag_l_r;
  logic [MAG_W-1:0]        mag_r_r;
  logic                    neg_l_r;
  logic                    neg_r_r;
  logic signed [RP_W-1:0]  rp_l_r;
  logic signed [RP_W-1:0]  rp_r_r;
  req_t                    req_l_r;
  req_t                    req_r_r;
  logic                    active_r;

  assign sum_l_s = $signed(frame.sum_left);
  assign sum_r_s = $signed(frame.sum_right);
  assign mag_l   = MAG_W'(sum_l_s[SUM_W-1] ? -sum_l_s : sum_l_s);
  assign mag_r   = MAG_W'(sum_r_s[SUM_W-1] ? -sum_r_s : sum_r_s);
  assign peak_x  = RP_W'({1'b0, frame.peak});
  assign rp_l    = RP_W'($signed(frame.req_left)) * peak_x;
  assign rp_r    = RP_W'($signed(frame.req_right)) * peak_x;
  assign active  = CMP_W'(frame.total) > CMP_W'(cfg.activity_threshold);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      mag_l_r  <= mag_l;
      mag_r_r  <= mag_r;
      neg_l_r  <= sum_l_s[SUM_W-1];
      neg_r_r  <= sum_r_s[SUM_W-1];
      rp_l_r   <= rp_l;
      rp_r_r   <= rp_r;
      req_l_r  <= $signed(frame.req_left);
      req_r_r  <= $signed(frame.req_right);
      active_r <= active;
    end
  end

  // Stage 4: quotient estimate by reciprocal, which is the true quotient or
  // one below it; requests reduced with truncation toward zero.
  logic [MAG_W+RECIP_W-1:0] pm_l;
  logic [MAG_W+RECIP_W-1:0] pm_r;
  logic signed [RP_W-1:0]   rpb_l;
  logic signed [RP_W-1:0]   rpb_r;
  logic signed [RP_W-1:0]   adj_full_l;
  logic signed [RP_W-1:0]   adj_full_r;
  logic signed [RED_W-1:0]  req_l_x;
  logic signed [RED_W-1:0]  req_r_x;
  logic signed [RED_W-1:0]  red_l;
  logic signed [RED_W-1:0]  red_r;

  logic [Q_W-1:0]           q0_l_r;
  logic [Q_W-1:0]           q0_r_r;
  logic [MAG_W-1:0]         mag4_l_r;
  logic [MAG_W-1:0]         mag4_r_r;
  logic                     neg4_l_r;
  logic                     neg4_r_r;
  logic signed [RED_W-1:0]  red_l_r;
  logic signed [RED_W-1:0]  red_r_r;

  localparam logic signed [RP_W-1:0] ROUND_BIAS = RP_W'((1 << REDUCE_SHIFT) - 1);

  assign pm_l       = MAG_W'(mag_l_r) * RECIP_W'(RECIP);
  assign pm_r       = MAG_W'(mag_r_r) * RECIP_W'(RECIP);
  assign rpb_l      = rp_l_r + (rp_l_r[RP_W-1] ? ROUND_BIAS : '0);
  assign rpb_r      = rp_r_r + (rp_r_r[RP_W-1] ? ROUND_BIAS : '0);
  assign adj_full_l = rpb_l >>> REDUCE_SHIFT;
  assign adj_full_r = rpb_r >>> REDUCE_SHIFT;
  assign req_l_x    = RED_W'(req_l_r);
  assign req_r_x    = RED_W'(req_r_r);
  assign red_l      = active_r ? (req_l_x - adj_full_l[RED_W-1:0]) : req_l_x;
  assign red_r      = active_r ? (req_r_x - adj_full_r[RED_W-1:0]) : req_r_x;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      q0_l_r   <= pm_l[DIV_SHIFT +: Q_W];
      q0_r_r   <= pm_r[DIV_SHIFT +: Q_W];
      mag4_l_r <= mag_l_r;
      mag4_r_r <= mag_r_r;
      neg4_l_r <= neg_l_r;
      neg4_r_r <= neg_r_r;
      red_l_r  <= red_l;
      red_r_r  <= red_r;
    end
  end

  // Stage 5: remainder check fixes the quotient, sign and offset applied.
  logic [MAG_W-1:0]         rem_l;
  logic [MAG_W-1:0]         rem_r;
  logic [Q_W-1:0]           q_l;
  logic [Q_W-1:0]           q_r;
  logic signed [QS_W-1:0]   qs_l;
  logic signed [QS_W-1:0]   qs_r;
  logic signed [MIX_W-1:0]  base_x;

  logic signed [MIX_W-1:0]  mix_l_r;
  logic signed [MIX_W-1:0]  mix_r_r;
  logic signed [RED_W-1:0]  red5_l_r;
  logic signed [RED_W-1:0]  red5_r_r;

  assign rem_l  = mag4_l_r - MAG_W'(q0_l_r) * MAG_W'(SUM_DIVISOR);
  assign rem_r  = mag4_r_r - MAG_W'(q0_r_r) * MAG_W'(SUM_DIVISOR);
  assign q_l    = q0_l_r + Q_W'(rem_l >= MAG_W'(SUM_DIVISOR));
  assign q_r    = q0_r_r + Q_W'(rem_r >= MAG_W'(SUM_DIVISOR));
  assign qs_l   = neg4_l_r ? -QS_W'({1'b0, q_l}) : QS_W'({1'b0, q_l});
  assign qs_r   = neg4_r_r ? -QS_W'({1'b0, q_r}) : QS_W'({1'b0, q_r});
  assign base_x = MIX_W'($signed(cfg.base_offset));

  always_ff @(posedge clk) begin
    if (en.s5) begin
      mix_l_r  <= MIX_W'(qs_l) + base_x;
      mix_r_r  <= MIX_W'(qs_r) + base_x;
      red5_l_r <= red_l_r;
      red5_r_r <= red_r_r;
    end
  end

  // Output stage: request added, then the symmetric clamp.
  logic signed [MIX_W-1:0] tot_l;
  logic signed [MIX_W-1:0] tot_r;
  logic signed [MIX_W-1:0] lim_pos;
  logic signed [MIX_W-1:0] lim_neg;
  logic signed [MIX_W-1:0] clamp_l;
  logic signed [MIX_W-1:0] clamp_r;
  speed_t                  left_r;
  speed_t                  right_r;

  assign tot_l   = mix_l_r + MIX_W'(red5_l_r);
  assign tot_r   = mix_r_r + MIX_W'(red5_r_r);
  assign lim_pos = MIX_W'({1'b0, cfg.speed_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    clamp_l = tot_l;
    if (tot_l > lim_pos) begin
      clamp_l = lim_pos;
    end else if (tot_l < lim_neg) begin
      clamp_l = lim_neg;
    end
    clamp_r = tot_r;
    if (tot_r > lim_pos) begin
      clamp_r = lim_pos;
    end else if (tot_r < lim_neg) begin
      clamp_r = lim_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en.so) begin
      left_r  <= clamp_l[SPEED_BITS-1:0];
      right_r <= clamp_r[SPEED_BITS-1:0];
    end
  end

  assign left_speed  = left_r;
  assign right_speed = right_r;

endmodule

`default_nettype wire

// File: hdl/proximity_avoidance_mixer_core.sv
// Throughput: one request per cycle, set by the six-stage pipeline in which
// every stage holds its own valid bit and stalls only when the one below is
// full and stalled. Synchronous active-low reset clears the valid bits and
// loads the registers with base_offset 150, speed_limit 800 and threshold 2400.
// ----------------------------------------------------------------------------
// proximity_avoidance_mixer_core
// Obstacle avoidance mixer: eight weighted sensor lanes, a merge stage and
// a scaling and clamping back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "proximity_avoidance_mixer_core_macros.svh"

module proximity_avoidance_mixer_core
  import pam_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

  input  logic                     in_tvalid,
  output logic                     in_tready,
  // sensor_0 .. sensor_7, request_left, request_right; zero padded
  input  logic [IN_DATA_BITS-1:0]  in_tdata,

  output logic                     out_tvalid,
  input  logic                     out_tready,
  // left_speed, right_speed; zero padded
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_offset        <= BASE_RESET;
      cfg_r.speed_limit        <= LIMIT_RESET;
      cfg_r.activity_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_addr))
        CFG_BASE_OFFSET: begin
          cfg_r.base_offset <= cfg_wdata[BASE_BITS-1:0];
        end
        CFG_SPEED_LIMIT: begin
          cfg_r.speed_limit <= cfg_wdata[LIMIT_BITS-1:0];
        end
        CFG_ACTIVITY_THRESHOLD: begin
          cfg_r.activity_threshold <= cfg_wdata[THRESH_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: each stage loads when it is empty or its contents move on.
  logic [4:0] v_r;
  logic       out_valid_r;
  stage_en_t  en;

  always_comb begin
    en.so = !out_valid_r || out_tready;
    en.s5 = !v_r[4] || en.so;
    en.s4 = !v_r[3] || en.s5;
    en.s3 = !v_r[2] || en.s4;
    en.s2 = !v_r[1] || en.s3;
    en.s1 = !v_r[0] || en.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v_r[0] <= in_tvalid;
      end
      if (en.s2) begin
        v_r[1] <= v_r[0];
      end
      if (en.s3) begin
        v_r[2] <= v_r[1];
      end
      if (en.s4) begin
        v_r[3] <= v_r[2];
      end
      if (en.s5) begin
        v_r[4] <= v_r[3];
      end
      if (en.so) begin
        out_valid_r <= v_r[4];
      end
    end
  end

  assign in_tready  = en.s1;
  assign out_tvalid = out_valid_r;

  // Stage 1: sensor lanes and the requests beside them.
  lane_out_t lanes [SENSOR_COUNT];
  req_t      req_left_r;
  req_t      req_right_r;

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    pam_lane u_lane (
      .clk     (clk),
      .en      (en.s1),
      .sensor  (in_tdata[i*SENSOR_BITS +: SENSOR_BITS]),
      .w_right (weight_at(i)),
      .w_left  (weight_at(i + SENSOR_COUNT)),
      .lane_q  (lanes[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      req_left_r  <= in_tdata[SENSOR_COUNT*SENSOR_BITS +: REQ_BITS];
      req_right_r <= in_tdata[SENSOR_COUNT*SENSOR_BITS + REQ_BITS +: REQ_BITS];
    end
  end

  // Stage 2: merge.
  frame_sum_t frame;

  pam_merge u_merge (
    .clk       (clk),
    .en        (en.s2),
    .lanes     (lanes),
    .req_left  (req_left_r),
    .req_right (req_right_r),
    .frame_q   (frame)
  );

  // Stages 3 to 5 and the output register.
  speed_t left_speed;
  speed_t right_speed;

  pam_post u_post (
    .clk         (clk),
    .en          (en),
    .cfg         (cfg_r),
    .frame       (frame),
    .left_speed  (left_speed),
    .right_speed (right_speed)
  );

  assign out_tdata = OUT_DATA_BITS'({right_speed, left_speed});

  `PAM_ASSERT_NEXT(a_s1_load, clk, rst_n, in_tvalid && in_tready, v_r[0], "accepted request was not captured")
  `PAM_ASSERT_NEXT(a_out_load, clk, rst_n, v_r[4] && en.so, out_tvalid, "result lost at the output register")
  `PAM_ASSERT_NOW(a_backpressure, clk, rst_n, (&v_r) && out_tvalid && !out_tready, !in_tready, "full pipeline accepted a request")

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Proximity avoidance mixer testbench
// Sends sensor frames with wheel requests through the mixer core under several
// register settings. An in-bench mixing model predicts both wheel speeds for
// every accepted request, and each result is checked against the oldest
// prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import pam_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_CAP  = 200;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 150;
  localparam int SENSOR_MAX  = (1 << SENSOR_BITS) - 1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam req_t REQ_MIN = 11'h400;
  localparam req_t REQ_MAX = 11'h3FF;

  // Packed so that sensor_0 sits in the lowest bits, as on in_tdata.
  typedef struct packed {
    req_t                          req_right;
    req_t                          req_left;
    sensor_t [SENSOR_COUNT-1:0]    sensor;
  } frame_t;

  typedef struct packed {
    speed_t right_speed;
    speed_t left_speed;
  } speeds_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  // sensor_0 .. sensor_7, request_left, request_right; zero padded
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // left_speed, right_speed; zero padded
  logic [OUT_DATA_BITS-1:0] out_tdata;

  // Mirror of the block's registers.
  logic signed [BASE_BITS-1:0] mixer_base = BASE_RESET;
  logic [LIMIT_BITS-1:0]       mixer_limit = LIMIT_RESET;
  logic [THRESH_BITS-1:0]      mixer_threshold = THRESHOLD_RESET;

  frame_t  frames_pending[$];
  speeds_t speeds_expected[$];
  frame_t  frame_now;
  int      in_hold = 0;
  int      out_hold = 0;
  bit      in_idle_on = 1'b1;
  bit      out_idle_on = 1'b1;
  int      faults = 0;

  proximity_avoidance_mixer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic speeds_t mix_speeds(frame_t f);
    longint  sum_r, sum_l, total, peak, s, rq_l, rq_r, lim, left, right;
    longint  w_r, w_l;
    int      i;
    speeds_t r;
    sum_r = 0;
    sum_l = 0;
    total = 0;
    peak  = 0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      s = longint'(f.sensor[i]);
      total += s;
      if (s > peak) peak = s;
      w_r = (i < WEIGHT_ENTRIES) ? longint'(WEIGHT_TABLE[i]) : 0;
      w_l = (i + SENSOR_COUNT < WEIGHT_ENTRIES) ?
            longint'(WEIGHT_TABLE[i + SENSOR_COUNT]) : 0;
      sum_r += w_r * s;
      sum_l += w_l * s;
    end
    sum_r = sum_r / SUM_DIVISOR + longint'(mixer_base);
    sum_l = sum_l / SUM_DIVISOR + longint'(mixer_base);
    rq_l = longint'(f.req_left);
    rq_r = longint'(f.req_right);
    // Strictly above the threshold only; equality leaves the requests alone.
    if (total > longint'(mixer_threshold)) begin
      rq_l -= (rq_l * peak) / (2 * FULL_SCALE);
      rq_r -= (rq_r * peak) / (2 * FULL_SCALE);
    end
    lim   = longint'(mixer_limit);
    left  = rq_l + sum_l;
    right = rq_r + sum_r;
    if (left > lim) left = lim;
    if (left < -lim) left = -lim;
    if (right > lim) right = lim;
    if (right < -lim) right = -lim;
    r.left_speed  = left[SPEED_BITS-1:0];
    r.right_speed = right[SPEED_BITS-1:0];
    return r;
  endfunction

  function automatic int draw_wait(bit on);
    if (!on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic req_t pick_request();
    case ($urandom_range(0, 7))
      0: return REQ_MIN;
      1: return REQ_MAX;
      2: return -REQ_MAX;
      3: return '0;
      default: return req_t'($urandom);
    endcase
  endfunction

  function automatic frame_t uniform_frame(sensor_t v, req_t l, req_t r);
    frame_t f;
    int     i;
    for (i = 0; i < SENSOR_COUNT; i++) f.sensor[i] = v;
    f.req_left  = l;
    f.req_right = r;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     i, mode, target, share, rest;
    mode = $urandom_range(0, 9);
    for (i = 0; i < SENSOR_COUNT; i++) begin
      case (mode)
        3, 4:    f.sensor[i] = sensor_t'($urandom_range(0, 300));
        5:       f.sensor[i] = $urandom_range(0, 1) ? sensor_t'(SENSOR_MAX) : '0;
        default: f.sensor[i] = sensor_t'($urandom);
      endcase
    end
    // Land the sensor total on the threshold or one above it.
    if (mode == 6 || mode == 7) begin
      target = int'(mixer_threshold) + $urandom_range(0, 1);
      if (target > SENSOR_COUNT * SENSOR_MAX) target = SENSOR_COUNT * SENSOR_MAX;
      share = target / SENSOR_COUNT;
      rest  = target % SENSOR_COUNT;
      for (i = 0; i < SENSOR_COUNT; i++) begin
        f.sensor[i] = sensor_t'(share + ((i < rest) ? 1 : 0));
      end
    end
    f.req_left  = pick_request();
    f.req_right = pick_request();
    return f;
  endfunction

  task automatic write_register(input logic [CFG_ADDR_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_BASE_OFFSET:        mixer_base = value[BASE_BITS-1:0];
      CFG_SPEED_LIMIT:        mixer_limit = value[LIMIT_BITS-1:0];
      CFG_ACTIVITY_THRESHOLD: mixer_threshold = value[THRESH_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frames_pending.size() != 0 || in_tvalid || speeds_expected.size() != 0);
  endtask

  // Request driver.
  always @(posedge clk) begin : drive_frames
    logic busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        speeds_expected.push_back(mix_speeds(frame_now));
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_hold > 0) begin
          in_hold--;
          in_tvalid <= 1'b0;
        end else if (frames_pending.size() != 0) begin
          frame_now = frames_pending.pop_front();
          in_tdata  <= IN_DATA_BITS'(frame_now);
          in_tvalid <= 1'b1;
          in_hold   = draw_wait(in_idle_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin : check_speeds
    speeds_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[2*SPEED_BITS-1:0];
        if (speeds_expected.size() == 0) begin
          faults++;
          if (faults <= REPORT_CAP)
            $error("result with no request waiting: left %0d right %0d",
                   $signed(got.left_speed), $signed(got.right_speed));
        end else begin
          want = speeds_expected.pop_front();
          if (got.left_speed !== want.left_speed) begin
            faults++;
            if (faults <= REPORT_CAP)
              $error("left_speed: expected %0d, got %0d",
                     $signed(want.left_speed), $signed(got.left_speed));
          end
          if (got.right_speed !== want.right_speed) begin
            faults++;
            if (faults <= REPORT_CAP)
              $error("right_speed: expected %0d, got %0d",
                     $signed(want.right_speed), $signed(got.right_speed));
          end
        end
        out_hold = draw_wait(out_idle_on);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Ends the run if work is outstanding and nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (frames_pending.size() == 0 && !in_tvalid && speeds_expected.size() == 0))
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    frame_t f;
    int     p, i, k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset settings.
    frames_pending.push_back(uniform_frame('0, '0, '0));
    frames_pending.push_back(uniform_frame(sensor_t'(SENSOR_MAX), REQ_MAX, REQ_MIN));
    frames_pending.push_back(uniform_frame(sensor_t'(SENSOR_MAX), REQ_MIN, REQ_MAX));
    frames_pending.push_back(uniform_frame(12'd300, 11'sd1000, -11'sd1000));
    f = uniform_frame(12'd300, 11'sd1000, -11'sd1000);
    f.sensor[3] = 12'd301;
    frames_pending.push_back(f);
    for (k = 0; k < SENSOR_COUNT; k++) begin
      f = uniform_frame('0, 11'sd500, -11'sd500);
      f.sensor[k] = sensor_t'(SENSOR_MAX);
      frames_pending.push_back(f);
    end
    frames_pending.push_back(uniform_frame('0, REQ_MIN, REQ_MIN));
    frames_pending.push_back(uniform_frame('0, REQ_MAX, REQ_MAX));
    frames_pending.push_back(uniform_frame(12'hAAA, 11'h555, 11'h2AA));
    frames_pending.push_back(uniform_frame(12'h555, 11'h2AA, 11'h555));

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        repeat (8) @(posedge clk);
        case (p)
          1: begin
            write_register(CFG_BASE_OFFSET, 15'h0200);
            write_register(CFG_SPEED_LIMIT, 15'd1023);
            write_register(CFG_ACTIVITY_THRESHOLD, 15'd0);
          end
          2: begin
            write_register(CFG_BASE_OFFSET, 15'd511);
            write_register(CFG_SPEED_LIMIT, 15'd0);
            write_register(CFG_ACTIVITY_THRESHOLD, 15'h7FFF);
          end
          3: begin
            write_register(CFG_BASE_OFFSET, 15'd0);
            write_register(CFG_SPEED_LIMIT, 15'd1023);
            write_register(CFG_ACTIVITY_THRESHOLD, 15'd32760);
          end
          default: begin
            // Upper data bits beyond each register's width are junk on purpose.
            write_register(CFG_BASE_OFFSET, CFG_DATA_BITS'($urandom));
            write_register(CFG_SPEED_LIMIT, CFG_DATA_BITS'($urandom));
            write_register(CFG_ACTIVITY_THRESHOLD,
                           $urandom_range(0, 1) ? CFG_DATA_BITS'($urandom_range(0, 12000))
                                                : CFG_DATA_BITS'($urandom));
          end
        endcase
        // A write to the unused index must leave every register alone.
        if ($urandom_range(0, 1)) write_register(CFG_SPARE_INDEX, CFG_DATA_BITS'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        in_idle_on  = (p == 1) ? 1'b0 : bit'($urandom_range(0, 1));
        out_idle_on = (p == 1) ? 1'b0 : bit'($urandom_range(0, 1));
      end
      for (i = 0; i < PHASE_ITEMS; i++) frames_pending.push_back(random_frame());
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (faults == 0 && speeds_expected.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
